// File: hw/rtl/tcw_pkg.sv
// Shared types, codes and the control store of the text console writer.
package tcw_pkg;

	// Field widths of the stream payloads.
	localparam int REQ_W   = 2;
	localparam int CHAR_W  = 8;
	localparam int IDX_W   = 11;
	localparam int ATTR_W  = 8;
	localparam int COLO_W  = 7;
	localparam int ROWO_W  = 5;
	localparam int OFF_W   = 11;
	localparam int CNT_W   = 3;
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 48;

	// Width of the control store address and of the tab repeat counter.
	localparam int UPC_W = 5;
	localparam int REP_W = 2;

	// Request kinds.
	typedef enum logic [REQ_W-1:0] {
		REQ_PUT   = 2'd0,
		REQ_READ  = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	// Control characters and fixed cell values.
	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [ATTR_W-1:0] ATTR_BLANK = 8'h00;
	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

	// Reported cell counts and the extra spaces of a tab.
	localparam logic [CNT_W-1:0] CNT_TAB  = 3'd4;
	localparam logic [CNT_W-1:0] CNT_ONE  = 3'd1;
	localparam logic [CNT_W-1:0] CNT_NONE = 3'd0;
	localparam logic [REP_W-1:0] TAB_REPEAT = 2'd3;
	localparam logic [REP_W-1:0] REP_NONE   = 2'd0;

	// Datapath operations selected by one control word.
	typedef enum logic [2:0] {
		WR_NONE, WR_CELL, WR_BLANK, WR_PAINT, WR_COPY
	} wr_op_t;

	typedef enum logic {
		WA_CURSOR, WA_SWEEP
	} wa_sel_t;

	typedef enum logic [1:0] {
		RD_NONE, RD_SCROLL, RD_CELL
	} rd_op_t;

	typedef enum logic [1:0] {
		COL_HOLD, COL_ZERO, COL_INC, COL_DEC
	} col_op_t;

	typedef enum logic [1:0] {
		ROW_HOLD, ROW_ZERO, ROW_INC
	} row_op_t;

	typedef enum logic [1:0] {
		SW_HOLD, SW_ZERO, SW_INC
	} sweep_op_t;

	typedef enum logic [3:0] {
		CD_NEXT, CD_ALWAYS, CD_WRAP, CD_LAST_ROW, CD_COL_ZERO, CD_REP_ZERO,
		CD_PUT_MODE, CD_NOT_COPY_END, CD_NOT_FILL_END
	} cond_t;

	typedef logic [UPC_W-1:0] upc_t;

	// Control store addresses.
	localparam upc_t UA_P0      = 5'd0;
	localparam upc_t UA_P1      = 5'd1;
	localparam upc_t UA_P2      = 5'd2;
	localparam upc_t UA_P3      = 5'd3;
	localparam upc_t UA_CR      = 5'd4;
	localparam upc_t UA_BS0     = 5'd5;
	localparam upc_t UA_BS1     = 5'd6;
	localparam upc_t UA_RD      = 5'd7;
	localparam upc_t UA_NL0     = 5'd8;
	localparam upc_t UA_NL1     = 5'd9;
	localparam upc_t UA_SC_RD   = 5'd10;
	localparam upc_t UA_SC_WR   = 5'd11;
	localparam upc_t UA_SC_FILL = 5'd12;
	localparam upc_t UA_NL_END  = 5'd13;
	localparam upc_t UA_PAINT   = 5'd14;
	localparam upc_t UA_CLR0    = 5'd15;
	localparam upc_t UA_CLR1    = 5'd16;
	localparam upc_t UA_FIN     = 5'd17;

	// One control word.
	typedef struct packed {
		wr_op_t    wr;
		wa_sel_t   wa;
		rd_op_t    rd;
		col_op_t   col;
		row_op_t   row;
		sweep_op_t sweep;
		logic      rep_dec;
		cond_t     cond;
		upc_t      target;
		logic      fin;
	} ucode_t;

	localparam ucode_t UCODE_NOP = '{
		wr: WR_NONE, wa: WA_CURSOR, rd: RD_NONE, col: COL_HOLD, row: ROW_HOLD,
		sweep: SW_HOLD, rep_dec: 1'b0, cond: CD_NEXT, target: '0, fin: 1'b0
	};

	// Datapath flags that the jump conditions test.
	typedef struct packed {
		logic wrap;
		logic last_row;
		logic col_zero;
		logic rep_zero;
		logic put_mode;
		logic copy_end;
		logic fill_end;
	} status_t;

	// Decoded request: entry point and the values latched at acceptance.
	typedef struct packed {
		upc_t              entry;
		logic [REP_W-1:0]  rep;
		logic              put_mode;
		logic [CHAR_W-1:0] put_char;
		logic [CNT_W-1:0]  cells;
		logic              is_read;
	} dispatch_t;

	// Result fields as they leave the datapath.
	typedef struct packed {
		logic [CNT_W-1:0]  cells;
		logic [ATTR_W-1:0] cell_attr;
		logic [CHAR_W-1:0] cell_char;
		logic [OFF_W-1:0]  offset;
		logic [ROWO_W-1:0] row;
		logic [COLO_W-1:0] col;
	} result_t;

	// Builds one control word.
	function automatic ucode_t uw(input wr_op_t wr, input wa_sel_t wa, input rd_op_t rd,
			input col_op_t col, input row_op_t row, input sweep_op_t sw,
			input logic rep_dec, input cond_t cond, input upc_t target, input logic fin);
		ucode_t w;
		w.wr      = wr;
		w.wa      = wa;
		w.rd      = rd;
		w.col     = col;
		w.row     = row;
		w.sweep   = sw;
		w.rep_dec = rep_dec;
		w.cond    = cond;
		w.target  = target;
		w.fin     = fin;
		return w;
	endfunction

	// The control program. A step without a taken jump falls to the next address.
	function automatic ucode_t ucode_rom(input upc_t a);
		ucode_t w;
		unique case (a)
			// Printable byte: newline first if a wrap is pending.
			UA_P0:      w = uw(WR_NONE, WA_CURSOR, RD_NONE, COL_HOLD, ROW_HOLD, SW_HOLD,
					1'b0, CD_WRAP, UA_NL0, 1'b0);
			UA_P1:      w = uw(WR_CELL, WA_CURSOR, RD_NONE, COL_INC, ROW_HOLD, SW_HOLD,
					1'b0, CD_NEXT, '0, 1'b0);
			UA_P2:      w = uw(WR_PAINT, WA_CURSOR, RD_NONE, COL_HOLD, ROW_HOLD, SW_HOLD,
					1'b0, CD_REP_ZERO, UA_FIN, 1'b0);
			UA_P3:      w = uw(WR_NONE, WA_CURSOR, RD_NONE, COL_HOLD, ROW_HOLD, SW_HOLD,
					1'b1, CD_ALWAYS, UA_P0, 1'b0);
			// Carriage return.
			UA_CR:      w = uw(WR_NONE, WA_CURSOR, RD_NONE, COL_ZERO, ROW_HOLD, SW_HOLD,
					1'b0, CD_ALWAYS, UA_PAINT, 1'b0);
			// Backspace.
			UA_BS0:     w = uw(WR_NONE, WA_CURSOR, RD_NONE, COL_HOLD, ROW_HOLD, SW_HOLD,
					1'b0, CD_COL_ZERO, UA_PAINT, 1'b0);
			UA_BS1:     w = uw(WR_BLANK, WA_CURSOR, RD_NONE, COL_DEC, ROW_HOLD, SW_HOLD,
					1'b0, CD_ALWAYS, UA_PAINT, 1'b0);
			// Cell read.
			UA_RD:      w = uw(WR_NONE, WA_CURSOR, RD_CELL, COL_HOLD, ROW_HOLD, SW_HOLD,
					1'b0, CD_ALWAYS, UA_FIN, 1'b0);
			// Newline, with a scroll on the last row.
			UA_NL0:     w = uw(WR_NONE, WA_CURSOR, RD_NONE, COL_ZERO, ROW_HOLD, SW_ZERO,
					1'b0, CD_LAST_ROW, UA_SC_RD, 1'b0);
			UA_NL1:     w = uw(WR_NONE, WA_CURSOR, RD_NONE, COL_HOLD, ROW_INC, SW_HOLD,
					1'b0, CD_ALWAYS, UA_NL_END, 1'b0);
			UA_SC_RD:   w = uw(WR_NONE, WA_SWEEP, RD_SCROLL, COL_HOLD, ROW_HOLD, SW_HOLD,
					1'b0, CD_NEXT, '0, 1'b0);
			UA_SC_WR:   w = uw(WR_COPY, WA_SWEEP, RD_NONE, COL_HOLD, ROW_HOLD, SW_INC,
					1'b0, CD_NOT_COPY_END, UA_SC_RD, 1'b0);
			UA_SC_FILL: w = uw(WR_BLANK, WA_SWEEP, RD_NONE, COL_HOLD, ROW_HOLD, SW_INC,
					1'b0, CD_NOT_FILL_END, UA_SC_FILL, 1'b0);
			UA_NL_END:  w = uw(WR_NONE, WA_CURSOR, RD_NONE, COL_HOLD, ROW_HOLD, SW_HOLD,
					1'b0, CD_PUT_MODE, UA_P1, 1'b0);
			// Final cursor paint.
			UA_PAINT:   w = uw(WR_PAINT, WA_CURSOR, RD_NONE, COL_HOLD, ROW_HOLD, SW_HOLD,
					1'b0, CD_ALWAYS, UA_FIN, 1'b0);
			// Clear screen, also run once after reset.
			UA_CLR0:    w = uw(WR_NONE, WA_SWEEP, RD_NONE, COL_ZERO, ROW_ZERO, SW_ZERO,
					1'b0, CD_NEXT, '0, 1'b0);
			UA_CLR1:    w = uw(WR_BLANK, WA_SWEEP, RD_NONE, COL_HOLD, ROW_HOLD, SW_INC,
					1'b0, CD_NOT_FILL_END, UA_CLR1, 1'b0);
			UA_FIN:     w = uw(WR_NONE, WA_CURSOR, RD_NONE, COL_HOLD, ROW_HOLD, SW_HOLD,
					1'b0, CD_NEXT, '0, 1'b1);
			default:    w = UCODE_NOP;
		endcase
		return w;
	endfunction

	// Decodes an incoming request into its program entry and latched values.
	function automatic dispatch_t dispatch(input logic [REQ_W-1:0] req,
			input logic [CHAR_W-1:0] ch);
		dispatch_t d;
		d.entry    = UA_FIN;
		d.rep      = REP_NONE;
		d.put_mode = 1'b0;
		d.put_char = ch;
		d.cells    = CNT_NONE;
		d.is_read  = 1'b0;
		unique case (req_t'(req))
			REQ_PUT: begin
				d.cells = CNT_ONE;
				unique case (ch)
					CH_TAB: begin
						d.entry    = UA_P0;
						d.rep      = TAB_REPEAT;
						d.put_mode = 1'b1;
						d.put_char = CH_SPACE;
						d.cells    = CNT_TAB;
					end
					CH_CR: d.entry = UA_CR;
					CH_LF: d.entry = UA_NL0;
					CH_BS: d.entry = UA_BS0;
					default: begin
						d.entry    = UA_P0;
						d.put_mode = 1'b1;
					end
				endcase
			end
			REQ_READ: begin
				d.entry   = UA_RD;
				d.is_read = 1'b1;
			end
			REQ_CLEAR: d.entry = UA_CLR0;
			REQ_NONE:  d.entry = UA_FIN;
			default:   d.entry = UA_FIN;
		endcase
		return d;
	endfunction

endpackage

// File: hw/rtl/tcw_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module tcw_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 2000,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hw/rtl/tcw_sequencer.sv
// Microprogram sequencer: step counter, control store and conditional jumps.
module tcw_sequencer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  tcw_pkg::upc_t    entry,
	input  tcw_pkg::status_t status,
	input  logic             stall,
	output tcw_pkg::ucode_t  ctrl,
	output logic             busy,
	output logic             emit
);

	tcw_pkg::upc_t   upc_q;
	logic            busy_q;
	logic            quiet_q;
	tcw_pkg::ucode_t word;
	logic            taken;

	// Fetch the current control word; idle cycles drive no operation.
	always_comb begin
		word = tcw_pkg::ucode_rom(upc_q);
		ctrl = busy_q ? word : tcw_pkg::UCODE_NOP;
	end

	// Jump condition.
	always_comb begin
		case (word.cond)
			tcw_pkg::CD_NEXT:         taken = 1'b0;
			tcw_pkg::CD_ALWAYS:       taken = 1'b1;
			tcw_pkg::CD_WRAP:         taken = status.wrap;
			tcw_pkg::CD_LAST_ROW:     taken = status.last_row;
			tcw_pkg::CD_COL_ZERO:     taken = status.col_zero;
			tcw_pkg::CD_REP_ZERO:     taken = status.rep_zero;
			tcw_pkg::CD_PUT_MODE:     taken = status.put_mode;
			tcw_pkg::CD_NOT_COPY_END: taken = !status.copy_end;
			tcw_pkg::CD_NOT_FILL_END: taken = !status.fill_end;
			default:                  taken = 1'b0;
		endcase
	end

	assign busy = busy_q;
	assign emit = busy_q && word.fin && !quiet_q && !stall;

	// Step counter. After reset the clear program runs once without a result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q   <= tcw_pkg::UA_CLR0;
			busy_q  <= 1'b1;
			quiet_q <= 1'b1;
		end else if (!busy_q) begin
			if (start) begin
				upc_q  <= entry;
				busy_q <= 1'b1;
			end
		end else if (word.fin) begin
			if (quiet_q || !stall) begin
				busy_q  <= 1'b0;
				quiet_q <= 1'b0;
			end
		end else begin
			upc_q <= taken ? word.target : upc_q + tcw_pkg::upc_t'(1);
		end
	end

	// The power-up clear never produces a result.
	a_quiet_no_emit: assert property (@(posedge clk) disable iff (!arst_n)
		quiet_q |-> !emit)
		else $error("result emitted during the power-up clear");

	// The step counter stays inside the program.
	a_upc_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (upc_q <= tcw_pkg::UA_FIN))
		else $error("step counter outside the control store");

endmodule

// File: hw/rtl/tcw_datapath.sv
// Cursor, sweep counter, cell stores and result assembly, driven by the control word.
module tcw_datapath #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  tcw_pkg::dispatch_t             disp,
	input  logic [tcw_pkg::IDX_W-1:0]      cell_index,
	input  logic [tcw_pkg::ATTR_W-1:0]     text_attribute,
	input  tcw_pkg::ucode_t                ctrl,
	output tcw_pkg::status_t               status,
	output tcw_pkg::result_t               result
);

	localparam int CELLS  = ROWS * COLUMNS;
	localparam int AW     = $clog2(CELLS);
	localparam int CIDX_W = $clog2(CELLS + 1);
	localparam int COL_W  = $clog2(COLUMNS + 1);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int IW     = tcw_pkg::IDX_W;
	localparam int CW     = tcw_pkg::CHAR_W;
	localparam int AT_W   = tcw_pkg::ATTR_W;
	localparam int OW     = tcw_pkg::OFF_W;
	localparam int COLO   = tcw_pkg::COLO_W;
	localparam int ROWO   = tcw_pkg::ROWO_W;

	localparam logic [COL_W-1:0]  COL_END     = COL_W'(COLUMNS);
	localparam logic [ROW_W-1:0]  ROW_LAST    = ROW_W'(ROWS - 1);
	localparam logic [AW-1:0]     SW_ROW      = AW'(COLUMNS);
	localparam logic [AW-1:0]     SW_FILL_END = AW'(CELLS - 1);
	localparam logic [AW-1:0]     SW_COPY_END = AW'(CELLS - COLUMNS - 1);
	localparam logic [CIDX_W-1:0] CIDX_CELLS  = CIDX_W'(CELLS);
	localparam logic [CIDX_W-1:0] CIDX_COLS   = CIDX_W'(COLUMNS);

	logic [COL_W-1:0]          col_q;
	logic [ROW_W-1:0]          row_q;
	logic [AW-1:0]             sweep_q;
	logic [tcw_pkg::REP_W-1:0] rep_q;
	logic                      put_mode_q;
	logic [CW-1:0]             put_char_q;
	logic [tcw_pkg::CNT_W-1:0] cells_q;
	logic [IW-1:0]             idx_q;
	logic                      rd_ok_q;

	logic [CIDX_W-1:0]    cur_idx;
	logic                 cur_ok;
	logic                 idx_ok;
	logic [AW+IW-1:0]     idx_wide;
	logic [AW-1:0]        waddr;
	logic                 addr_ok;
	logic                 char_we;
	logic                 attr_we;
	logic [CW-1:0]        char_wdata;
	logic [AT_W-1:0]      attr_wdata;
	logic                 rd_en;
	logic [AW-1:0]        raddr;
	logic [CW-1:0]        char_rdata;
	logic [AT_W-1:0]      attr_rdata;

	// Linear cursor position and screen bounds.
	always_comb begin
		cur_idx  = CIDX_W'(row_q) * CIDX_COLS + CIDX_W'(col_q);
		cur_ok   = cur_idx < CIDX_CELLS;
		idx_ok   = {{CIDX_W{1'b0}}, cell_index} < {{IW{1'b0}}, CIDX_CELLS};
		idx_wide = {{AW{1'b0}}, idx_q};
	end

	// Write port: address, guard and data per operation.
	always_comb begin
		waddr   = (ctrl.wa == tcw_pkg::WA_SWEEP) ? sweep_q : cur_idx[AW-1:0];
		addr_ok = (ctrl.wa == tcw_pkg::WA_SWEEP) || cur_ok;
		char_we    = 1'b0;
		attr_we    = 1'b0;
		char_wdata = tcw_pkg::CH_SPACE;
		attr_wdata = tcw_pkg::ATTR_BLANK;
		case (ctrl.wr)
			tcw_pkg::WR_CELL: begin
				char_we    = addr_ok;
				attr_we    = addr_ok;
				char_wdata = put_char_q;
				attr_wdata = text_attribute;
			end
			tcw_pkg::WR_BLANK: begin
				char_we = addr_ok;
				attr_we = addr_ok;
			end
			tcw_pkg::WR_PAINT: begin
				attr_we    = addr_ok;
				attr_wdata = text_attribute;
			end
			tcw_pkg::WR_COPY: begin
				char_we    = addr_ok;
				attr_we    = addr_ok;
				char_wdata = char_rdata;
				attr_wdata = attr_rdata;
			end
			default: begin
				char_we = 1'b0;
				attr_we = 1'b0;
			end
		endcase
	end

	// Read port: one row further on while scrolling, else the requested cell.
	always_comb begin
		rd_en = ctrl.rd != tcw_pkg::RD_NONE;
		raddr = (ctrl.rd == tcw_pkg::RD_SCROLL) ? sweep_q + SW_ROW : idx_wide[AW-1:0];
	end

	tcw_ram #(.WIDTH(CW), .DEPTH(CELLS), .ADDR_W(AW)) u_char_ram (
		.clk   (clk),
		.we    (char_we),
		.waddr (waddr),
		.wdata (char_wdata),
		.re    (rd_en),
		.raddr (raddr),
		.rdata (char_rdata)
	);

	tcw_ram #(.WIDTH(AT_W), .DEPTH(CELLS), .ADDR_W(AW)) u_attr_ram (
		.clk   (clk),
		.we    (attr_we),
		.waddr (waddr),
		.wdata (attr_wdata),
		.re    (rd_en),
		.raddr (raddr),
		.rdata (attr_rdata)
	);

	// Cursor, sweep and repeat counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			sweep_q    <= '0;
			rep_q      <= '0;
			put_mode_q <= 1'b0;
		end else begin
			if (start) begin
				rep_q      <= disp.rep;
				put_mode_q <= disp.put_mode;
			end else if (ctrl.rep_dec) begin
				rep_q <= rep_q - tcw_pkg::REP_W'(1);
			end
			case (ctrl.col)
				tcw_pkg::COL_ZERO: col_q <= '0;
				tcw_pkg::COL_INC:  col_q <= col_q + COL_W'(1);
				tcw_pkg::COL_DEC:  col_q <= col_q - COL_W'(1);
				default:           col_q <= col_q;
			endcase
			case (ctrl.row)
				tcw_pkg::ROW_ZERO: row_q <= '0;
				tcw_pkg::ROW_INC:  row_q <= row_q + ROW_W'(1);
				default:           row_q <= row_q;
			endcase
			case (ctrl.sweep)
				tcw_pkg::SW_ZERO: sweep_q <= '0;
				tcw_pkg::SW_INC:  sweep_q <= sweep_q + AW'(1);
				default:          sweep_q <= sweep_q;
			endcase
		end
	end

	// Request values held for the run of the program.
	always_ff @(posedge clk) begin
		if (start) begin
			put_char_q <= disp.put_char;
			cells_q    <= disp.cells;
			idx_q      <= cell_index;
			rd_ok_q    <= disp.is_read && idx_ok;
		end
	end

	// Flags for the jump conditions.
	always_comb begin
		status.wrap     = col_q == COL_END;
		status.last_row = row_q == ROW_LAST;
		status.col_zero = col_q == '0;
		status.rep_zero = rep_q == '0;
		status.put_mode = put_mode_q;
		status.copy_end = sweep_q == SW_COPY_END;
		status.fill_end = sweep_q == SW_FILL_END;
	end

	// Result fields; cell data only for an in-range read.
	always_comb begin
		result.col       = COLO'(col_q);
		result.row       = ROWO'(row_q);
		result.offset    = OW'(cur_idx);
		result.cell_char = rd_ok_q ? char_rdata : '0;
		result.cell_attr = rd_ok_q ? attr_rdata : '0;
		result.cells     = cells_q;
	end

	// The cursor never leaves the screen, apart from the pending-wrap column.
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= COL_END)
		else $error("cursor column beyond the pending-wrap position");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= ROW_LAST)
		else $error("cursor row beyond the last row");

	// Sweep writes always land inside the screen.
	a_sweep_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.wr != tcw_pkg::WR_NONE && ctrl.wa == tcw_pkg::WA_SWEEP)
			|-> ({1'b0, sweep_q} < (AW+1)'(CELLS)))
		else $error("sweep write outside the screen");

endmodule

// File: hw/rtl/text_console_writer_top.sv
// Text console writer. Holds a COLUMNS x ROWS screen of character and attribute
// cells and a cursor, and answers put-character, read-cell and clear requests,
// one result per request. A small microprogram steps a shared cell datapath,
// one step per clock while no finished result waits on a stalled output, so
// the time per request follows the program; a printable byte first moves to
// the next row when a wrap is pending. A newline on the last row scrolls the
// screen through the single read and write port of the cell memories: each
// of the (ROWS-1)*COLUMNS moved cells is read and then written one row up,
// and the last row is then blanked. After reset the same clear pass runs
// before the first request is accepted; configuration writes are taken at
// any time. One request is worked at a time; the next one is accepted while
// the previous result still waits at the output.
module text_console_writer_top #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration: text_attribute.
	input  logic                           cfg_wen,
	input  logic [tcw_pkg::ATTR_W-1:0]     cfg_wdata,
	// Requests.
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// char_code [7:0], cell_index [18:8], zero [23:19].
	input  logic [tcw_pkg::S_DATA_W-1:0]   s_axis_tdata,
	// req_type [1:0].
	input  logic [tcw_pkg::REQ_W-1:0]      s_axis_tuser,
	// Results.
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// cursor_col [6:0], cursor_row [11:7], cursor_offset [22:12],
	// cell_char [30:23], cell_attr [38:31], cells_counted [41:39], zero [47:42].
	output logic [tcw_pkg::M_DATA_W-1:0]   m_axis_tdata
);

	localparam int RES_W = $bits(tcw_pkg::result_t);

	logic [tcw_pkg::ATTR_W-1:0] attr_q;
	logic                       m_valid_q;
	tcw_pkg::result_t           m_data_q;
	logic                       accept;
	logic                       busy;
	logic                       emit;
	logic                       stall;
	tcw_pkg::dispatch_t         disp;
	tcw_pkg::ucode_t            ctrl;
	tcw_pkg::status_t           status;
	tcw_pkg::result_t           result;

	// Request handshake and decode.
	always_comb begin
		s_axis_tready = !busy;
		accept        = s_axis_tvalid && s_axis_tready;
		stall         = m_valid_q && !m_axis_tready;
		disp          = tcw_pkg::dispatch(s_axis_tuser, s_axis_tdata[7:0]);
	end

	// Attribute register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= tcw_pkg::ATTR_RESET;
		end else if (cfg_wen) begin
			attr_q <= cfg_wdata;
		end
	end

	tcw_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.entry  (disp.entry),
		.status (status),
		.stall  (stall),
		.ctrl   (ctrl),
		.busy   (busy),
		.emit   (emit)
	);

	tcw_datapath #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (accept),
		.disp           (disp),
		.cell_index     (s_axis_tdata[18:8]),
		.text_attribute (attr_q),
		.ctrl           (ctrl),
		.status         (status),
		.result         (result)
	);

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			m_data_q <= result;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(tcw_pkg::M_DATA_W - RES_W){1'b0}}, m_data_q};

	// A new result is only loaded when the output register is free.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!m_valid_q || m_axis_tready))
		else $error("result overwrote a pending result");

	// Only one request is in work at a time.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_axis_tready)
		else $error("request accepted while another is in work");

endmodule
